@@ hw/rtl/c2p_pkg.sv @@
package c2p_pkg;

   localparam int ITERATIONS_DEFAULT = 16;
   localparam int FRAC_BITS = 8;
   localparam int CORDIC_WIDTH = 35;
   localparam int SQRT_STEPS = 16;
   localparam int ATAN_LEN = 24;
   localparam int SQRT_TOP_SHIFT = 2 * (SQRT_STEPS - 1);

   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [15:0] THREE_QUARTER_TURN = 16'd49152;
   localparam logic [31:0] HALF_TURN_ACC = 32'h8000_0000;
   localparam logic [31:0] ANGLE_ROUND = 32'h0000_8000;

   localparam logic signed [17:0] NEAR_LO = -18'sd3 <<< FRAC_BITS;
   localparam logic signed [17:0] NEAR_HI = 18'sd1 <<< FRAC_BITS;

   localparam logic [31:0] ATAN_UNITS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [15:0] radius;
      logic [15:0] angle;
   } rsp_type;

   typedef struct packed {
      logic signed [CORDIC_WIDTH-1:0] cx;
      logic signed [CORDIC_WIDTH-1:0] cy;
      logic [31:0] acc;
      logic [31:0] rem;
      logic [31:0] root;
      logic x_zero;
      logic y_pos;
      logic near;
   } work_type;

endpackage

@@ hw/rtl/cartesian_to_polar_core.sv @@
// cartesian to polar conversion, fully pipelined
// req channel: one beat carries a signed q8.8 point (x_coord, y_coord)
// rsp channel: one beat carries radius (unsigned q8.8, rounded) and angle
// in binary angle units (65536 = full turn, 0 = +x axis)
// every beat in yields exactly one beat out, in order
// stages: one input stage, one stage per cordic micro-rotation / square root
// digit, one output stage
// throughput: one beat per cycle while rsp_ready is high
// each stage holds its own valid bit and takes new data when it is empty
// or its successor moves, so a stall on rsp_ready backs up stage by stage
// and empty slots still fill; req_ready drops only once every stage is full
// reset clears all valid bits; no results are pending afterwards
// the near-origin threshold follows FRAC_BITS in the package
module cartesian_to_polar_core #(
   parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  c2p_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output c2p_pkg::rsp_type rsp_data
);
   import c2p_pkg::*;

   localparam int DEPTH = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

   work_type stage_data [DEPTH+1];
   logic stage_valid [DEPTH+1];
   logic stage_ready [DEPTH+1];

   c2p_prep u_prep (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .in_data(req_data),
      .out_valid(stage_valid[0]),
      .out_ready(stage_ready[0]),
      .out_data(stage_data[0])
   );

   for (genvar k = 0; k < DEPTH; k++) begin : g_step
      c2p_step #(
         .STEP(k),
         .ITERATIONS(ITERATIONS)
      ) u_step (
         .clock(clock),
         .reset(reset),
         .in_valid(stage_valid[k]),
         .in_ready(stage_ready[k]),
         .in_data(stage_data[k]),
         .out_valid(stage_valid[k+1]),
         .out_ready(stage_ready[k+1]),
         .out_data(stage_data[k+1])
      );
   end

   c2p_final u_final (
      .clock(clock),
      .reset(reset),
      .in_valid(stage_valid[DEPTH]),
      .in_ready(stage_ready[DEPTH]),
      .in_data(stage_data[DEPTH]),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data(rsp_data)
   );

endmodule

@@ hw/rtl/c2p_prep.sv @@
module c2p_prep (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  c2p_pkg::req_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output c2p_pkg::work_type out_data
);
   import c2p_pkg::*;

   logic valid_ff, valid_in;
   work_type data_ff, data_in;
   logic signed [CORDIC_WIDTH-1:0] xe, ye;
   logic signed [31:0] xsq, ysq;
   logic signed [17:0] x2, y2;
   logic neg;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      xe = CORDIC_WIDTH'(in_data.x_coord);
      ye = CORDIC_WIDTH'(in_data.y_coord);
      neg = in_data.x_coord < 0;
      xsq = 32'(in_data.x_coord) * 32'(in_data.x_coord);
      ysq = 32'(in_data.y_coord) * 32'(in_data.y_coord);
      x2 = {in_data.x_coord[15], in_data.x_coord, 1'b0};
      y2 = {in_data.y_coord[15], in_data.y_coord, 1'b0};
      data_in.cx = (neg ? -xe : xe) <<< 16;
      data_in.cy = (neg ? -ye : ye) <<< 16;
      data_in.acc = neg ? HALF_TURN_ACC : 32'd0;
      data_in.rem = $unsigned(xsq) + $unsigned(ysq);
      data_in.root = 32'd0;
      data_in.x_zero = in_data.x_coord == 16'sd0;
      data_in.y_pos = in_data.y_coord > 16'sd0;
      data_in.near = (x2 > NEAR_LO) && (x2 < NEAR_HI) && (y2 > NEAR_LO) && (y2 < NEAR_HI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ hw/rtl/c2p_step.sv @@
module c2p_step #(
   parameter int STEP = 0,
   parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  c2p_pkg::work_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output c2p_pkg::work_type out_data
);
   import c2p_pkg::*;

   localparam bit DO_CORDIC = STEP < ITERATIONS;
   localparam bit DO_SQRT = STEP < SQRT_STEPS;
   localparam int SQ_SHIFT = DO_SQRT ? SQRT_TOP_SHIFT - 2 * STEP : 0;
   localparam int AT_IDX = DO_CORDIC ? STEP : 0;
   localparam logic [31:0] SQ_BIT = 32'd1 << SQ_SHIFT;

   logic valid_ff, valid_in;
   work_type data_ff, data_in;
   logic signed [CORDIC_WIDTH-1:0] xs, ys;
   logic [32:0] trial;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in = in_data;
      xs = in_data.cx >>> STEP;
      ys = in_data.cy >>> STEP;
      trial = {1'b0, in_data.root} + {1'b0, SQ_BIT};
      if (DO_CORDIC) begin
         if (in_data.cy > 0) begin
            data_in.cx = in_data.cx + ys;
            data_in.cy = in_data.cy - xs;
            data_in.acc = in_data.acc + ATAN_UNITS[AT_IDX];
         end else begin
            data_in.cx = in_data.cx - ys;
            data_in.cy = in_data.cy + xs;
            data_in.acc = in_data.acc - ATAN_UNITS[AT_IDX];
         end
      end
      if (DO_SQRT) begin
         if ({1'b0, in_data.rem} >= trial) begin
            data_in.rem = in_data.rem - trial[31:0];
            data_in.root = (in_data.root >> 1) + SQ_BIT;
         end else begin
            data_in.root = in_data.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ hw/rtl/c2p_final.sv @@
module c2p_final (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  c2p_pkg::work_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output c2p_pkg::rsp_type out_data
);
   import c2p_pkg::*;

   logic valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic [31:0] acc_round;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      acc_round = in_data.acc + ANGLE_ROUND;
      data_in.radius = in_data.root[15:0] + 16'(in_data.rem > in_data.root);
      if (in_data.near) begin
         data_in.angle = 16'd0;
      end else if (in_data.x_zero) begin
         data_in.angle = in_data.y_pos ? QUARTER_TURN : THREE_QUARTER_TURN;
      end else begin
         data_in.angle = acc_round[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule
